[rtl/aenc_pkg.sv]
package aenc_pkg;

    // one assembler instruction
    typedef struct packed {
        logic [6:0]  cmd;
        logic [4:0]  arg0;
        logic [4:0]  arg1;
        logic [4:0]  arg2;
        logic [4:0]  arg3;
        logic [4:0]  arg4;
        logic [63:0] ct_value;
        logic [11:0] word_index;
        logic        is_last;
    } t_enc_in;

    // encoded word and status
    typedef struct packed {
        logic [31:0] machine_word;
        logic [2:0]  error_code;
        logic        end_of_program;
    } t_enc_out;

    typedef enum logic [2:0] {
        ERR_OK     = 3'd0,
        ERR_FIELD  = 3'd1,
        ERR_IMM    = 3'd2,
        ERR_BRANCH = 3'd3,
        ERR_UNSUP  = 3'd4
    } t_err;

    // mnemonic codes for single instructions and the codes that open or close a group
    localparam logic [6:0] CMD_NOP   = 7'd0;
    localparam logic [6:0] CMD_EMITD = 7'd1;
    localparam logic [6:0] CMD_SVC   = 7'd2;
    localparam logic [6:0] CMD_CFINV = 7'd3;
    localparam logic [6:0] CMD_BR    = 7'd4;
    localparam logic [6:0] CMD_B     = 7'd5;
    localparam logic [6:0] CMD_BC    = 7'd6;
    localparam logic [6:0] CMD_MOVZX = 7'd7;
    localparam logic [6:0] CMD_MOVNW = 7'd12;
    localparam logic [6:0] CMD_ADDIX = 7'd13;
    localparam logic [6:0] CMD_ADDHWS = 7'd20;
    localparam logic [6:0] CMD_ADCX  = 7'd21;
    localparam logic [6:0] CMD_ADCWS = 7'd26;
    localparam logic [6:0] CMD_CSELX = 7'd27;
    localparam logic [6:0] CMD_CSNEGW = 7'd34;
    localparam logic [6:0] CMD_ADR   = 7'd35;
    localparam logic [6:0] CMD_ORRX  = 7'd36;
    localparam logic [6:0] CMD_SUBWS = 7'd47;
    localparam logic [6:0] CMD_LD64B = 7'd48;
    localparam logic [6:0] CMD_ST64B = 7'd49;
    localparam logic [6:0] CMD_ABSX  = 7'd50;
    localparam logic [6:0] CMD_REVHW = 7'd65;

    // fixed words
    localparam logic [31:0] WORD_NOP   = 32'hD503201F;
    localparam logic [31:0] WORD_SVC   = 32'hD4000001;
    localparam logic [31:0] WORD_CFINV = 32'hD500401F;

endpackage

[rtl/aenc_encode.sv]
module aenc_encode (
    input  aenc_pkg::t_enc_in  i_item,
    output aenc_pkg::t_enc_out o_result
);
    import aenc_pkg::*;

    localparam logic [7:0]  MOV_OP [3]     = '{8'hA5, 8'hE5, 8'h25};
    localparam logic [8:0]  ADC_OP [3]     = '{9'h0D0, 9'h1D0, 9'h0D6};
    localparam logic [6:0]  SHREG_OP [6]   = '{7'h2A, 7'h2A, 7'h0B, 7'h2B, 7'h4B, 7'h6B};
    localparam logic [3:0]  ONE_SRC_OPC [8] = '{4'd8, 4'd5, 4'd4, 4'd6, 4'd7, 4'd0, 4'd2, 4'd1};

    logic [6:0]  c;
    logic [31:0] off;
    logic [6:0]  kdiff;
    logic [2:0]  k;
    logic        sf;
    logic [3:0]  opc;
    logic [31:0] word;
    t_err        err;

    always_comb begin
        c     = i_item.cmd;
        off   = i_item.ct_value[31:0] - {20'd0, i_item.word_index};
        kdiff = '0;
        k     = '0;
        sf    = 1'b0;
        opc   = '0;
        word  = '0;
        err   = ERR_OK;

        if (c == CMD_NOP) begin
            word = WORD_NOP;
        end else if (c == CMD_EMITD) begin
            word = i_item.ct_value[31:0];
        end else if (c == CMD_SVC) begin
            word = WORD_SVC;
        end else if (c == CMD_CFINV) begin
            word = WORD_CFINV;
        end else if (c == CMD_BR) begin
            word = {22'h3587C0, i_item.arg0, 5'd0};
        end else if (c == CMD_B) begin
            // signed 26-bit word offset: top bits all equal
            if (off[31:25] != 7'h00 && off[31:25] != 7'h7F) begin
                err = ERR_BRANCH;
            end else begin
                word = {6'b000101, off[25:0]};
            end
        end else if (c == CMD_BC) begin
            if (i_item.arg1[4]) begin
                err = ERR_FIELD;
            end else if (off[31:18] != 14'h0000 && off[31:18] != 14'h3FFF) begin
                err = ERR_BRANCH;
            end else begin
                word = {8'h54, off[18:0], i_item.arg1};
            end
        end else if (c inside {[CMD_MOVZX:CMD_MOVNW]}) begin
            sf    = c[0];
            kdiff = c - CMD_MOVZX;
            k     = {1'b0, kdiff[2:1]};
            if (i_item.arg1[4:2] != 3'd0 || (!sf && i_item.arg1[1])) begin
                err = ERR_FIELD;
            end else if (|i_item.ct_value[63:16]) begin
                err = ERR_IMM;
            end else begin
                word = {sf, MOV_OP[k[1:0]], i_item.arg1[1:0], i_item.ct_value[15:0],
                        i_item.arg2};
            end
        end else if (c inside {[CMD_ADDIX:CMD_ADDHWS]}) begin
            kdiff = c - CMD_ADDIX;
            k     = kdiff[2:0];
            sf    = ~k[0];
            if (|i_item.ct_value[63:12]) begin
                err = ERR_IMM;
            end else begin
                word = {sf, 1'b0, (k[2] ? 7'h62 : 7'h22), k[1], i_item.ct_value[11:0],
                        i_item.arg1, i_item.arg2};
            end
        end else if (c inside {[CMD_ADCX:CMD_ADCWS]}) begin
            sf    = c[0];
            kdiff = c - CMD_ADCX;
            k     = {1'b0, kdiff[2:1]};
            word  = {sf, 1'b0, ADC_OP[k[1:0]], i_item.arg0,
                     (k[1] ? 6'h0A : 6'h00), i_item.arg1, i_item.arg2};
        end else if (c inside {[CMD_CSELX:CMD_CSNEGW]}) begin
            sf    = c[0];
            kdiff = c - CMD_CSELX;
            k     = {1'b0, kdiff[2:1]};
            if (i_item.arg3[4]) begin
                err = ERR_FIELD;
            end else begin
                word = {sf, (k[1] ? 10'h2D4 : 10'h0D4), i_item.arg0, i_item.arg3[3:0],
                        1'b0, k[0], i_item.arg1, i_item.arg2};
            end
        end else if (c == CMD_ADR) begin
            err = ERR_UNSUP;
        end else if (c inside {[CMD_ORRX:CMD_SUBWS]}) begin
            sf    = ~c[0];
            kdiff = c - CMD_ORRX;
            k     = kdiff[3:1];
            // rotate shift reserved for add and sub forms
            if (i_item.arg1[4:2] != 3'd0 || (k >= 3'd2 && i_item.arg1[1:0] == 2'd3)) begin
                err = ERR_FIELD;
            end else if (|i_item.ct_value[63:6] || (!sf && i_item.ct_value[5])) begin
                err = ERR_IMM;
            end else begin
                word = {sf, SHREG_OP[k], i_item.arg1[1:0], (k == 3'd1), i_item.arg2,
                        i_item.ct_value[5:0], i_item.arg3, i_item.arg4};
            end
        end else if (c == CMD_LD64B || c == CMD_ST64B) begin
            word = {1'b1, (c == CMD_LD64B ? 21'h1E0FF4 : 21'h1E0FE4), i_item.arg0,
                    i_item.arg1};
        end else if (c inside {[CMD_ABSX:CMD_REVHW]}) begin
            sf    = ~c[0];
            kdiff = c - CMD_ABSX;
            k     = kdiff[3:1];
            opc   = ONE_SRC_OPC[k];
            // 64-bit rev has its own opcode
            if (k == 3'd6 && sf) begin
                opc = 4'd3;
            end
            word = {sf, 21'h16B000 | {17'd0, opc}, i_item.arg0, i_item.arg1};
        end else begin
            err = ERR_UNSUP;
        end

        if (err != ERR_OK) begin
            word = '0;
        end

        o_result.machine_word   = word;
        o_result.error_code     = err;
        o_result.end_of_program = i_item.is_last;
    end

endmodule

[rtl/arm64_instruction_encoder_core.sv]
// channel | direction | valid       | stall       | payload
// input   | in        | i_in_valid  | o_in_stall  | i_in_data  (t_enc_in)
// output  | out       | o_out_valid | i_out_stall | o_out_data (t_enc_out)
//
// one transaction per cycle sustained while the output is not stalled; an accepted
// transaction passes the input register, the encode logic and the result
// register before it shows as output valid
// the encode logic between the two registers sets the cycle time
// synchronous active-low reset clears both valid flags only
// an output stall freezes the result register; the input register is then
// held and the input channel stalls only once it is full
module arm64_instruction_encoder_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  aenc_pkg::t_enc_in  i_in_data,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output aenc_pkg::t_enc_out o_out_data,
    input  logic               i_out_stall
);
    import aenc_pkg::*;

    // input register
    logic     r_in_valid;
    logic     n_in_valid;
    t_enc_in  r_in;

    // result register
    logic     r_out_valid;
    logic     n_out_valid;
    t_enc_out r_out;

    t_enc_out enc_result;
    logic     out_load;
    logic     in_load;

    aenc_encode u_encode (
        .i_item   (r_in),
        .o_result (enc_result)
    );

    // result register takes a new transaction when empty or draining
    assign out_load   = ~r_out_valid | ~i_out_stall;
    // input register refills when empty or when its item moves on
    assign o_in_stall = r_in_valid & ~out_load;
    assign in_load    = i_in_valid & ~o_in_stall;

    always_comb begin
        n_in_valid  = in_load | (r_in_valid & ~out_load);
        n_out_valid = out_load ? r_in_valid : r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_load) begin
            r_in <= i_in_data;
        end
        if (out_load && r_in_valid) begin
            r_out <= enc_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // errored instructions never carry a word
    a_err_zero_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.error_code != ERR_OK) |-> (o_out_data.machine_word == 32'd0))
        else $error("errored result carries a nonzero word");

    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.error_code <= ERR_UNSUP))
        else $error("error code out of range");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("input stalled with room downstream");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_in_valid)
        else $error("accepted transaction lost at input register");

    a_advance_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && out_load) |=> o_out_valid)
        else $error("advanced transaction missing at output");

endmodule
